/* rtl/pts_pkg.sv */
`default_nettype none

package pts_pkg;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_SCHED   = 3'd1,
    ACT_ADD     = 3'd2,
    ACT_KILL_ID = 3'd3,
    ACT_KILL_CUR = 3'd4,
    ACT_SLEEP   = 3'd5,
    ACT_BLOCK   = 3'd6,
    ACT_NOP     = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_LAST    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    logic        alive;
    logic [7:0]  prio;
    logic        asleep;
    logic [31:0] remain;
    logic        blocked;
    logic [15:0] ident;
  } entry_t;

  localparam logic [7:0] PRIO_IDLE = 8'd255;
  localparam logic [8:0] BEST_NONE = 9'd256;

  function automatic entry_t reset_entry(input logic first);
    entry_t e;
    e = '0;
    if (first) begin
      e.alive = 1'b1;
      e.prio  = PRIO_IDLE;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/pts_table.sv */
`default_nettype none

module pts_table #(
  parameter int unsigned SLOTS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [$clog2(SLOTS)-1:0]     rd_addr_i,
  input  wire                          wr_en_i,
  input  wire  [$clog2(SLOTS)-1:0]     wr_addr_i,
  input  wire  pts_pkg::entry_t        wr_data_i,
  output pts_pkg::entry_t              rd_data_o,
  output logic [$clog2(SLOTS)-1:0]     rd_slot_o
);
  import pts_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);

  entry_t          mem [SLOTS];
  entry_t          rd_q;
  logic [SLOTS-1:0] vld_q;
  logic            rvld_q;
  logic [AW-1:0]   rslot_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q    <= mem[rd_addr_i];
    rslot_q <= rd_addr_i;
  end

  // entries never written read as their reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr_i];
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rvld_q ? rd_q : reset_entry(rslot_q == '0);
  assign rd_slot_o = rslot_q;

endmodule

`default_nettype wire

/* rtl/priority_thread_scheduler_top.sv */
// Channel  Dir  Signals
// in       in   in_valid_i / in_ready_o, action_i priority_req_i target_id_i
//               sleep_ticks_i blocked_flag_i
// out      out  out_valid_o / out_ready_i, status_o running_slot_o running_id_o
//               new_id_o thread_count_o switch_request_o
// One transaction at a time: out_valid_o rises after one sweep of the thread table through
// its single read port, then the S_DRAIN, S_WB, S_RD and S_FIN states; in_ready_o stays low
// until the result is loaded, so no new transaction is taken before then.
// Reset is immediate; no clearing pass (per-entry valid bits).
// A result waiting on out_ready_i holds the block before it loads the next one.
`default_nettype none

module priority_thread_scheduler_top #(
  parameter int unsigned THREAD_SLOTS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  action_i,
  input  wire  [7:0]  priority_req_i,
  input  wire  [15:0] target_id_i,
  input  wire  [31:0] sleep_ticks_i,
  input  wire         blocked_flag_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  running_slot_o,
  output logic [15:0] running_id_o,
  output logic [15:0] new_id_o,
  output logic [4:0]  thread_count_o,
  output logic        switch_request_o
);
  import pts_pkg::*;

  localparam int unsigned SW = $clog2(THREAD_SLOTS);
  localparam int unsigned CW = $clog2(THREAD_SLOTS + 1);
  localparam logic [CW-1:0] N_C  = CW'(THREAD_SLOTS);
  localparam logic [CW:0]   N_CX = (CW + 1)'(THREAD_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_WB, S_RD, S_FIN
  } state_e;

  state_e        state_q;
  action_e       act_q;
  logic [7:0]    prio_q;
  logic [15:0]   tid_q;
  logic [31:0]   ticks_q;
  logic          bflag_q;
  logic [CW-1:0] k_q;
  logic          pv_q;
  logic [SW-1:0] cur_q, cur_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   nid_q, nid_d;
  status_e       st_q, st_d;
  logic          sw_q, sw_d;
  logic [15:0]   newid_q, newid_d;

  // sweep results
  logic          hit_q;
  logic [SW-1:0] hit_s_q;
  entry_t        hit_e_q;
  logic [8:0]    ba_p_q, be_p_q;
  logic [SW-1:0] ba_s_q, be_s_q, fs_q;
  logic          fa_q, frdy_q, calive_q;
  logic [7:0]    fp_q;

  logic [SW-1:0] rd_addr, wr_addr, rs;
  logic          wr_en;
  entry_t        wr_e, re;

  logic          wb_we;
  logic [SW-1:0] wb_s;
  entry_t        wb_e;

  logic          rot;
  logic [CW:0]   t_sum;
  logic [SW-1:0] scan_s;

  pts_table #(.SLOTS(THREAD_SLOTS)) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_e),
    .rd_data_o (re),
    .rd_slot_o (rs)
  );

  assign rot = (act_q == ACT_SCHED) || (act_q == ACT_KILL_ID) || (act_q == ACT_BLOCK);

  always_comb begin
    if (act_q == ACT_SCHED) begin
      t_sum = (CW + 1)'(cur_q) + (CW + 1)'(k_q) + (CW + 1)'(1);
    end else if (rot) begin
      t_sum = (CW + 1)'(k_q) + (CW + 1)'(1);
    end else begin
      t_sum = (CW + 1)'(k_q);
    end
    if (t_sum >= N_CX) begin
      t_sum = t_sum - N_CX;
    end
    scan_s = t_sum[SW-1:0];
  end

  assign rd_addr = (state_q == S_SCAN) ? scan_s : cur_q;

  logic tick_we;
  assign tick_we = pv_q && (act_q == ACT_TICK) && re.alive && re.asleep;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wb_s;
    wr_e    = wb_e;
    if (tick_we) begin
      wr_en   = 1'b1;
      wr_addr = rs;
      wr_e    = re;
      if (re.remain == '0) begin
        wr_e.asleep = 1'b0;
      end else begin
        wr_e.remain = re.remain - 32'd1;
      end
    end else if (state_q == S_WB) begin
      wr_en = wb_we;
    end
  end

  // decisions once the sweep is done
  always_comb begin
    wb_we   = 1'b0;
    wb_s    = hit_s_q;
    wb_e    = hit_e_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    nid_d   = nid_q;
    st_d    = ST_OK;
    sw_d    = 1'b0;
    newid_d = '0;
    unique case (act_q)
      ACT_TICK: sw_d = 1'b1;
      ACT_SCHED: begin
        if (calive_q) begin
          cur_d = (ba_p_q != BEST_NONE) ? ba_s_q : cur_q;
        end else if (frdy_q && ({1'b0, fp_q} < be_p_q)) begin
          cur_d = fs_q;
        end else if (be_p_q != BEST_NONE) begin
          cur_d = be_s_q;
        end else begin
          cur_d = fs_q;
        end
      end
      ACT_ADD: begin
        if ((cnt_q >= N_C) || !hit_q) begin
          st_d = ST_LIMIT;
        end else begin
          wb_we   = 1'b1;
          wb_e    = '0;
          wb_e.alive = 1'b1;
          wb_e.prio  = prio_q;
          wb_e.ident = nid_q;
          newid_d = nid_q;
          nid_d   = nid_q + 16'd1;
          cnt_d   = cnt_q + CW'(1);
        end
      end
      ACT_KILL_ID, ACT_KILL_CUR: begin
        if (cnt_q <= CW'(1)) begin
          st_d = ST_LAST;
        end else if (!hit_q || !hit_e_q.alive) begin
          st_d = ST_MISSING;
        end else begin
          wb_we = 1'b1;
          wb_e.alive   = 1'b0;
          wb_e.blocked = 1'b0;
          cnt_d = cnt_q - CW'(1);
          sw_d  = (act_q == ACT_KILL_CUR) || (hit_s_q == cur_q);
        end
      end
      ACT_SLEEP: begin
        wb_we = 1'b1;
        wb_s  = cur_q;
        wb_e.remain = ticks_q;
        wb_e.asleep = 1'b1;
        sw_d  = 1'b1;
      end
      ACT_BLOCK: begin
        if (!hit_q) begin
          st_d = ST_MISSING;
        end else begin
          wb_we = 1'b1;
          wb_e.blocked = bflag_q;
          sw_d  = (hit_s_q == cur_q) && bflag_q;
        end
      end
      ACT_NOP: ;
      default: ;
    endcase
  end

  logic rdy, match;
  always_comb begin
    rdy = re.alive && !re.blocked && !re.asleep;
    unique case (act_q)
      ACT_ADD:                   match = !re.alive;
      ACT_KILL_ID, ACT_BLOCK:    match = re.alive && (re.ident == tid_q);
      ACT_KILL_CUR, ACT_SLEEP:   match = (rs == cur_q);
      default:                   match = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      hit_q  <= 1'b0;
      fa_q   <= 1'b0;
      ba_p_q <= BEST_NONE;
      be_p_q <= BEST_NONE;
    end else if (pv_q) begin
      if (match && !hit_q) begin
        hit_q   <= 1'b1;
        hit_s_q <= rs;
        hit_e_q <= re;
      end
      if (rdy && ({1'b0, re.prio} < ba_p_q)) begin
        ba_p_q <= {1'b0, re.prio};
        ba_s_q <= rs;
      end
      if (re.alive && !fa_q) begin
        fa_q   <= 1'b1;
        fs_q   <= rs;
        frdy_q <= rdy;
        fp_q   <= re.prio;
      end else if (rdy && ({1'b0, re.prio} < be_p_q)) begin
        be_p_q <= {1'b0, re.prio};
        be_s_q <= rs;
      end
      if (rs == cur_q) begin
        calive_q <= re.alive;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      pv_q        <= 1'b0;
      cur_q       <= '0;
      cnt_q       <= CW'(1);
      nid_q       <= 16'd1;
      st_q        <= ST_OK;
      sw_q        <= 1'b0;
      newid_q     <= '0;
      out_valid_o <= 1'b0;
      act_q       <= ACT_NOP;
      prio_q      <= '0;
      tid_q       <= '0;
      ticks_q     <= '0;
      bflag_q     <= 1'b0;
      status_o        <= '0;
      running_slot_o  <= '0;
      running_id_o    <= '0;
      new_id_o        <= '0;
      thread_count_o  <= '0;
      switch_request_o <= 1'b0;
    end else begin
      pv_q <= (state_q == S_SCAN);
      if (out_valid_o && out_ready_i && (state_q != S_FIN)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          k_q <= '0;
          if (in_valid_i) begin
            act_q   <= action_e'(action_i);
            prio_q  <= priority_req_i;
            tid_q   <= target_id_i;
            ticks_q <= sleep_ticks_i;
            bflag_q <= blocked_flag_i;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          k_q <= k_q + CW'(1);
          if (k_q == N_C - CW'(1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: state_q <= S_WB;
        S_WB: begin
          cur_q   <= cur_d;
          cnt_q   <= cnt_d;
          nid_q   <= nid_d;
          st_q    <= st_d;
          sw_q    <= sw_d;
          newid_q <= newid_d;
          state_q <= S_RD;
        end
        S_RD: state_q <= S_FIN;
        S_FIN: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o      <= 1'b1;
            status_o         <= st_q;
            running_slot_o   <= 4'(cur_q);
            running_id_o     <= re.ident;
            new_id_o         <= newid_q;
            thread_count_o   <= 5'(cnt_q);
            switch_request_o <= sw_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

/* verif/priority_thread_scheduler_checker.sv */
`timescale 1ns / 1ps

module priority_thread_scheduler_checker #(
  parameter int unsigned SLOTS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [2:0]  action_i,
  input  wire  [7:0]  priority_req_i,
  input  wire  [15:0] target_id_i,
  input  wire  [31:0] sleep_ticks_i,
  input  wire         blocked_flag_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [1:0]  status_i,
  input  wire  [3:0]  running_slot_i,
  input  wire  [15:0] running_id_i,
  input  wire  [15:0] new_id_i,
  input  wire  [4:0]  thread_count_i,
  input  wire         switch_request_i,
  output int          failures_o,
  output int          pending_o
);
  import pts_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] run_id;
    logic [15:0] new_id;
    logic [4:0]  count;
    logic        sw;
  } sched_result_t;

  logic        alive   [SLOTS];
  logic [7:0]  prio    [SLOTS];
  logic        asleep  [SLOTS];
  logic [31:0] remain  [SLOTS];
  logic        blocked [SLOTS];
  logic [15:0] ident   [SLOTS];
  int unsigned cur_slot;
  int unsigned live;
  logic [15:0] next_id;

  sched_result_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic int unsigned slot_of_id(input logic [15:0] id);
    int unsigned s;
    for (int unsigned k = 1; k <= SLOTS; k++) begin
      s = (k == SLOTS) ? 0 : k;
      if (alive[s] && ident[s] == id) return s;
    end
    return SLOTS;
  endfunction

  function automatic sched_result_t schedule_step(input action_e act, input logic [7:0] p,
                                                  input logic [15:0] tid,
                                                  input logic [31:0] ticks, input logic bf);
    sched_result_t r;
    int unsigned s, base, pick, best;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_TICK: begin
        for (int unsigned i = 0; i < SLOTS; i++)
          if (alive[i] && asleep[i]) begin
            if (remain[i] == 0) asleep[i] = 1'b0;
            else remain[i] = remain[i] - 1;
          end
        r.sw = 1'b1;
      end
      ACT_SCHED: begin
        base = cur_slot;
        best = 256;
        pick = SLOTS;
        if (!alive[base]) begin
          s = base;
          for (int unsigned k = 0; k < SLOTS; k++) begin
            s = (s + 1) % SLOTS;
            if (alive[s]) break;
          end
          base = s;
        end
        s = base;
        for (int unsigned k = 0; k < SLOTS; k++) begin
          s = (s + 1) % SLOTS;
          if (alive[s] && !blocked[s] && !asleep[s] && prio[s] < best) begin
            best = prio[s];
            pick = s;
          end
        end
        cur_slot = (pick < SLOTS) ? pick : base;
      end
      ACT_ADD: begin
        s = 0;
        while (s < SLOTS && alive[s]) s++;
        if (live >= SLOTS || s >= SLOTS) r.status = ST_LIMIT;
        else begin
          alive[s] = 1'b1;
          asleep[s] = 1'b0;
          blocked[s] = 1'b0;
          remain[s] = '0;
          prio[s] = p;
          ident[s] = next_id;
          r.new_id = next_id;
          next_id = next_id + 16'd1;
          live++;
        end
      end
      ACT_KILL_ID: begin
        s = slot_of_id(tid);
        if (live <= 1) r.status = ST_LAST;
        else if (s >= SLOTS) r.status = ST_MISSING;
        else begin
          alive[s] = 1'b0;
          blocked[s] = 1'b0;
          live--;
          r.sw = (s == cur_slot);
        end
      end
      ACT_KILL_CUR: begin
        if (live <= 1) r.status = ST_LAST;
        else if (!alive[cur_slot]) r.status = ST_MISSING;
        else begin
          alive[cur_slot] = 1'b0;
          blocked[cur_slot] = 1'b0;
          live--;
          r.sw = 1'b1;
        end
      end
      ACT_SLEEP: begin
        remain[cur_slot] = ticks;
        asleep[cur_slot] = 1'b1;
        r.sw = 1'b1;
      end
      ACT_BLOCK: begin
        s = slot_of_id(tid);
        if (s >= SLOTS) r.status = ST_MISSING;
        else begin
          blocked[s] = bf;
          r.sw = (s == cur_slot) && bf;
        end
      end
      default: ;
    endcase
    r.slot = cur_slot[3:0];
    r.run_id = ident[cur_slot];
    r.count = live[4:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t got, exp_r;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < SLOTS; i++) begin
        alive[i] = (i == 0);
        prio[i] = (i == 0) ? PRIO_IDLE : 8'd0;
        asleep[i] = 1'b0;
        remain[i] = '0;
        blocked[i] = 1'b0;
        ident[i] = '0;
      end
      cur_slot = 0;
      live = 1;
      next_id = 16'd1;
      failures_o = 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(schedule_step(action_e'(action_i), priority_req_i, target_id_i,
                                           sleep_ticks_i, blocked_flag_i));
      if (out_valid_i && out_ready_i) begin
        got = '{status_i, running_slot_i, running_id_i, new_id_i, thread_count_i,
                switch_request_i};
        if (expected_q.size() == 0) begin
          failures_o++;
          if (failures_o <= 10) $display("unexpected transaction %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            failures_o++;
            if (failures_o <= 10)
              $display("mismatch: expected %p, actual %p", exp_r, got);
          end
        end
      end
    end
  end

endmodule

/* verif/priority_thread_scheduler_top_tb.sv */
`timescale 1ns / 1ps

module priority_thread_scheduler_top_tb;
  import pts_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = '0;
  logic [7:0]  priority_req = '0;
  logic [15:0] target_id = '0;
  logic [31:0] sleep_ticks = '0;
  logic        blocked_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [3:0]  running_slot;
  logic [15:0] running_id;
  logic [15:0] new_id;
  logic [4:0]  thread_count;
  logic        switch_request;
  int          failures;
  int          pending;
  int          idle_cycles = 0;
  int          adds_sent = 0;
  int          burst_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  priority_thread_scheduler_top dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .priority_req_i(priority_req), .target_id_i(target_id),
    .sleep_ticks_i(sleep_ticks), .blocked_flag_i(blocked_flag),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .running_slot_o(running_slot), .running_id_o(running_id),
    .new_id_o(new_id), .thread_count_o(thread_count), .switch_request_o(switch_request)
  );

  priority_thread_scheduler_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .action_i(action), .priority_req_i(priority_req), .target_id_i(target_id),
    .sleep_ticks_i(sleep_ticks), .blocked_flag_i(blocked_flag),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .running_slot_i(running_slot), .running_id_i(running_id),
    .new_id_i(new_id), .thread_count_i(thread_count),
    .switch_request_i(switch_request),
    .failures_o(failures), .pending_o(pending)
  );

  // receiver stall pattern: a randomly redrawn mode sets how out_ready is driven
  always @(negedge clk_i) begin
    int unsigned mode;
    int unsigned phase;
    phase = phase + 1;
    if (phase % 64 == 0) mode = $urandom_range(0, 3);
    case (mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ((phase / 5) % 2 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input action_e a, input logic [7:0] p, input logic [15:0] t,
                           input logic [31:0] ticks, input logic bf);
    int gap;
    in_valid <= 1'b1;
    action <= a;
    priority_req <= p;
    target_id <= t;
    sleep_ticks <= ticks;
    blocked_flag <= bf;
    if (a == ACT_ADD) adds_sent++;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  function automatic action_e pick_action();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 20) return ACT_TICK;
    if (w < 44) return ACT_SCHED;
    if (w < 64) return ACT_ADD;
    if (w < 73) return ACT_KILL_ID;
    if (w < 79) return ACT_KILL_CUR;
    if (w < 87) return ACT_SLEEP;
    if (w < 97) return ACT_BLOCK;
    return ACT_NOP;
  endfunction

  initial begin
    action_e a;
    logic [15:0] t;
    logic [31:0] ticks;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(ACT_TICK, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_SCHED, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_KILL_CUR, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_KILL_ID, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_ADD, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_ADD, 8'd255, 16'd0, 32'd0, 1'b0);
    for (int i = 0; i < 15; i++)
      send_item(ACT_ADD, 8'(i * 17), 16'hffff, 32'hffff_ffff, 1'b1);
    send_item(ACT_BLOCK, 8'd0, 16'hffff, 32'd0, 1'b1);
    send_item(ACT_BLOCK, 8'd0, 16'd1, 32'd0, 1'b1);
    send_item(ACT_SCHED, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_SLEEP, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_SLEEP, 8'd0, 16'd0, 32'hffff_ffff, 1'b0);
    send_item(ACT_KILL_CUR, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_KILL_CUR, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_SCHED, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_KILL_ID, 8'd0, 16'd3, 32'd0, 1'b0);
    send_item(ACT_KILL_ID, 8'd0, 16'd3, 32'd0, 1'b0);
    send_item(ACT_BLOCK, 8'd0, 16'd1, 32'd0, 1'b0);
    send_item(ACT_TICK, 8'd0, 16'd0, 32'd0, 1'b0);
    send_item(ACT_NOP, 8'hff, 16'hffff, 32'hffff_ffff, 1'b1);

    for (int n = 0; n < 1200; n++) begin
      a = pick_action();
      t = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(0, adds_sent + 1));
      ticks = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 6);
      send_item(a, 8'($urandom), t, ticks, 1'($urandom));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (failures == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
